// ----- rtl/core/rtte_pkg.sv -----
`timescale 1ns / 1ps

package rtte_pkg;

    // default parameter values
    localparam int RTT_BITS_DEF    = 24;
    localparam int MAX_BACKOFF_DEF = 15;

    // field widths
    localparam int TIME_W     = 32;
    localparam int ACK_W      = 16;
    localparam int CNT_W      = 4;
    localparam int OUT_RTT_W  = 24;
    localparam int LOSS_W     = 25;
    localparam int DEADLINE_W = 33;
    localparam int MAD_W      = 14;
    localparam int INIT_W     = 16;
    localparam int GRAN_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // saturation limits
    localparam logic [LOSS_W-1:0] LOSS_MAX    = '1;
    localparam logic [TIME_W-1:0] TIMEOUT_MAX = '1;

    // register reset values
    localparam logic [MAD_W-1:0]  MAD_RESET  = MAD_W'(25);
    localparam logic [INIT_W-1:0] INIT_RESET = INIT_W'(333);
    localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_DELAY_CAP = 2'd0,
        CFG_INITIAL_RTT   = 2'd1,
        CFG_GRANULARITY   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_REPORT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [MAD_W-1:0]  ack_delay_cap;
        logic [INIT_W-1:0] initial_rtt;
        logic [GRAN_W-1:0] granularity;
    } cfg_t;

endpackage

// ----- rtl/core/rtte_req_if.sv -----
`timescale 1ns / 1ps

interface rtte_req_if;
    import rtte_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [TIME_W-1:0] time_ms;
    logic [TIME_W-1:0] sent_time_ms;
    logic [ACK_W-1:0]  ack_delay_ms;
    logic [CNT_W-1:0]  backoff_count;

    modport source (
        output valid, command, time_ms, sent_time_ms, ack_delay_ms, backoff_count,
        input  ready
    );

    modport sink (
        input  valid, command, time_ms, sent_time_ms, ack_delay_ms, backoff_count,
        output ready
    );
endinterface

// ----- rtl/core/rtte_rsp_if.sv -----
`timescale 1ns / 1ps

interface rtte_rsp_if;
    import rtte_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OUT_RTT_W-1:0]  latest_rtt_ms;
    logic [OUT_RTT_W-1:0]  min_rtt_ms;
    logic [OUT_RTT_W-1:0]  smoothed_rtt_ms;
    logic [OUT_RTT_W-1:0]  rtt_variance_ms;
    logic                  have_sample;
    logic [LOSS_W-1:0]     loss_delay_ms;
    logic [DEADLINE_W-1:0] pto_deadline_ms;

    modport source (
        output valid, latest_rtt_ms, min_rtt_ms, smoothed_rtt_ms, rtt_variance_ms,
               have_sample, loss_delay_ms, pto_deadline_ms,
        input  ready
    );

    modport sink (
        input  valid, latest_rtt_ms, min_rtt_ms, smoothed_rtt_ms, rtt_variance_ms,
               have_sample, loss_delay_ms, pto_deadline_ms,
        output ready
    );
endinterface

// ----- rtl/core/rtte_cfg_if.sv -----
`timescale 1ns / 1ps

interface rtte_cfg_if;
    import rtte_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/core/rtte_update.sv -----
`timescale 1ns / 1ps

module rtte_update #(
    parameter int RTT_BITS = rtte_pkg::RTT_BITS_DEF
) (
    input  logic [rtte_pkg::MAD_W-1:0]  ack_delay_cap,
    input  logic                        command,
    input  logic [rtte_pkg::TIME_W-1:0] time_ms,
    input  logic [rtte_pkg::TIME_W-1:0] sent_time_ms,
    input  logic [rtte_pkg::ACK_W-1:0]  ack_delay_ms,
    input  logic                        seen,
    input  logic [RTT_BITS-1:0]         latest,
    input  logic [RTT_BITS-1:0]         minimum,
    input  logic [RTT_BITS-1:0]         smoothed,
    input  logic [RTT_BITS-1:0]         deviation,
    output logic                        seen_new,
    output logic [RTT_BITS-1:0]         latest_new,
    output logic [RTT_BITS-1:0]         minimum_new,
    output logic [RTT_BITS-1:0]         smoothed_new,
    output logic [RTT_BITS-1:0]         deviation_new
);
    import rtte_pkg::*;

    localparam int RW1 = RTT_BITS + 1;
    localparam int RW2 = RTT_BITS + 2;
    localparam int RW3 = RTT_BITS + 3;
    localparam logic [TIME_W-1:0] RTT_MAX32 = TIME_W'((64'd1 << RTT_BITS) - 64'd1);

    logic [TIME_W:0]     diff;
    logic [TIME_W-1:0]   raw;
    logic [RTT_BITS-1:0] sample;
    logic [RTT_BITS-1:0] min_upd;
    logic [ACK_W-1:0]    bounded;
    logic [RW1-1:0]      min_plus;
    logic [RTT_BITS-1:0] adj;
    logic [RTT_BITS-1:0] delta;
    logic [RW2-1:0]      dev_sum;
    logic [RW3-1:0]      sm_sum;

    always_comb
    begin
        // ack before send gives a zero sample
        diff   = {1'b0, time_ms} - {1'b0, sent_time_ms};
        raw    = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
        sample = (raw > RTT_MAX32) ? RTT_MAX32[RTT_BITS-1:0] : raw[RTT_BITS-1:0];

        min_upd = (sample < minimum) ? sample : minimum;
        bounded = (ack_delay_ms < ACK_W'(ack_delay_cap)) ? ack_delay_ms
                                                         : ACK_W'(ack_delay_cap);

        // only subtract ack delay when it keeps the sample at or above min
        min_plus = RW1'(min_upd) + RW1'(bounded);
        adj      = (RW1'(sample) >= min_plus) ? sample - RTT_BITS'(bounded) : sample;
        delta    = (smoothed > adj) ? smoothed - adj : adj - smoothed;

        dev_sum = RW2'({deviation, 1'b0}) + RW2'(deviation) + RW2'(delta);
        sm_sum  = RW3'({smoothed, 3'b000}) - RW3'(smoothed) + RW3'(adj);

        seen_new      = seen;
        latest_new    = latest;
        minimum_new   = minimum;
        smoothed_new  = smoothed;
        deviation_new = deviation;

        if (command == CMD_SAMPLE)
        begin
            seen_new   = 1'b1;
            latest_new = sample;
            if (!seen)
            begin
                minimum_new   = sample;
                smoothed_new  = sample;
                deviation_new = sample >> 1;
            end
            else
            begin
                minimum_new   = min_upd;
                smoothed_new  = sm_sum[RW3-1:3];
                deviation_new = dev_sum[RW2-1:2];
            end
        end
    end

endmodule

// ----- rtl/core/rtte_timers.sv -----
`timescale 1ns / 1ps

module rtte_timers #(
    parameter int RTT_BITS    = rtte_pkg::RTT_BITS_DEF,
    parameter int MAX_BACKOFF = rtte_pkg::MAX_BACKOFF_DEF
) (
    input  logic [rtte_pkg::MAD_W-1:0]      ack_delay_cap,
    input  logic [rtte_pkg::INIT_W-1:0]     initial_rtt,
    input  logic [rtte_pkg::GRAN_W-1:0]     granularity,
    input  logic                            seen,
    input  logic [RTT_BITS-1:0]             latest,
    input  logic [RTT_BITS-1:0]             smoothed,
    input  logic [RTT_BITS-1:0]             deviation,
    input  logic [rtte_pkg::TIME_W-1:0]     time_ms,
    input  logic [rtte_pkg::CNT_W-1:0]      backoff_count,
    output logic [rtte_pkg::LOSS_W-1:0]     loss_delay_ms,
    output logic [rtte_pkg::DEADLINE_W-1:0] pto_deadline_ms
);
    import rtte_pkg::*;

    localparam int RW1  = RTT_BITS + 1;
    localparam int RW2  = RTT_BITS + 2;
    localparam int RW4  = RTT_BITS + 4;
    localparam int LDW  = (RW1 > LOSS_W) ? RW1 : LOSS_W;
    localparam int TW   = (RTT_BITS + 3 > TIME_W) ? RTT_BITS + 3 : TIME_W;
    localparam int BO_W = (MAX_BACKOFF > 1) ? $clog2(MAX_BACKOFF + 1) : 1;
    localparam int SW   = TIME_W + MAX_BACKOFF;

    logic [RTT_BITS-1:0] base;
    logic [RW4-1:0]      base9;
    logic [LDW-1:0]      loss_w;
    logic [RW2-1:0]      var4;
    logic [TW-1:0]       tmo_w;
    logic [TIME_W-1:0]   tmo32;
    logic [BO_W-1:0]     cnt_eff;
    logic [SW-1:0]       tmo_sh;
    logic [TIME_W-1:0]   tmo_fin;

    always_comb
    begin
        // loss delay: ceil(9/8 * base), floored at granularity and capped at LOSS_MAX
        if (seen)
            base = (latest > smoothed) ? latest : smoothed;
        else
            base = RTT_BITS'(initial_rtt);
        base9  = RW4'({base, 3'b000}) + RW4'(base) + RW4'(3'd7);
        loss_w = LDW'(base9[RW4-1:3]);
        if (loss_w < LDW'(granularity))
            loss_w = LDW'(granularity);
        if (loss_w > LDW'(LOSS_MAX))
            loss_w = LDW'(LOSS_MAX);
        loss_delay_ms = loss_w[LOSS_W-1:0];

        // probe timeout before backoff
        var4 = {deviation, 2'b00};
        if (var4 < RW2'(granularity))
            var4 = RW2'(granularity);
        if (seen)
            tmo_w = TW'(smoothed) + TW'(var4) + TW'(ack_delay_cap);
        else
            tmo_w = TW'({initial_rtt, 1'b0}) + TW'(initial_rtt);
        tmo32 = (tmo_w > TW'(TIMEOUT_MAX)) ? TIMEOUT_MAX : tmo_w[TIME_W-1:0];

        // doubling with saturation is one shift and an overflow check
        if (32'(backoff_count) > 32'(MAX_BACKOFF))
            cnt_eff = BO_W'(MAX_BACKOFF);
        else
            cnt_eff = BO_W'(backoff_count);
        tmo_sh  = SW'(tmo32) << cnt_eff;
        tmo_fin = (|tmo_sh[SW-1:TIME_W]) ? TIMEOUT_MAX : tmo_sh[TIME_W-1:0];

        pto_deadline_ms = {1'b0, time_ms} + {1'b0, tmo_fin};
    end

endmodule

// ----- rtl/core/rtt_estimator_with_pto.sv -----
`timescale 1ns / 1ps

// channel   dir   transfer content
// -------   ---   ----------------------------------------------------------
// req       in    command, time_ms, sent_time_ms, ack_delay_ms, backoff_count
// rsp       out   latest/min/smoothed rtt, variance, have_sample, loss, pto
// cfg       in    index, data (max ack delay, initial rtt, granularity)
//
// one transfer per cycle sustained while rsp takes results; after its req
// transfer a result passes the input register, the estimator update into
// stage 2 and the timer math into the output register
// the estimator state is written in the update stage, so the next item sees it
// rsp stalls ripple back to req.ready; nothing is dropped or repeated
// rst_n clears the estimator state, valid bits and config to reset values
// cfg is always ready; writes are expected only while the block is idle

module rtt_estimator_with_pto #(
    parameter int RTT_BITS    = rtte_pkg::RTT_BITS_DEF,
    parameter int MAX_BACKOFF = rtte_pkg::MAX_BACKOFF_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rtte_req_if.sink   req,
    rtte_rsp_if.source rsp,
    rtte_cfg_if.sink   cfg
);
    import rtte_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // estimator state
    logic                sample_seen_reg;
    logic [RTT_BITS-1:0] latest_rtt_reg;
    logic [RTT_BITS-1:0] minimum_rtt_reg;
    logic [RTT_BITS-1:0] smoothed_rtt_reg;
    logic [RTT_BITS-1:0] rtt_deviation_reg;

    // stage 1: input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_command_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic [TIME_W-1:0] s1_sent_reg;
    logic [ACK_W-1:0]  s1_ack_reg;
    logic [CNT_W-1:0]  s1_count_reg;

    // stage 2: snapshot of the updated state for the timer math
    logic                s2_valid_reg;
    logic                s2_valid_next;
    logic                s2_seen_reg;
    logic [RTT_BITS-1:0] s2_latest_reg;
    logic [RTT_BITS-1:0] s2_minimum_reg;
    logic [RTT_BITS-1:0] s2_smoothed_reg;
    logic [RTT_BITS-1:0] s2_deviation_reg;
    logic [TIME_W-1:0]   s2_time_reg;
    logic [CNT_W-1:0]    s2_count_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_RTT_W-1:0]  out_latest_reg;
    logic [OUT_RTT_W-1:0]  out_minimum_reg;
    logic [OUT_RTT_W-1:0]  out_smoothed_reg;
    logic [OUT_RTT_W-1:0]  out_deviation_reg;
    logic                  out_seen_reg;
    logic [LOSS_W-1:0]     out_loss_reg;
    logic [DEADLINE_W-1:0] out_pto_reg;

    // pipeline advance
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic s1_fire;
    logic s2_fire;

    // combinational results
    logic                  seen_new;
    logic [RTT_BITS-1:0]   latest_new;
    logic [RTT_BITS-1:0]   minimum_new;
    logic [RTT_BITS-1:0]   smoothed_new;
    logic [RTT_BITS-1:0]   deviation_new;
    logic [LOSS_W-1:0]     loss_delay;
    logic [DEADLINE_W-1:0] pto_deadline;

    assign out_en  = !out_valid_reg || rsp.ready;
    assign s2_en   = !s2_valid_reg || out_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s1_fire = s1_valid_reg && s2_en;
    assign s2_fire = s2_valid_reg && out_en;

    assign req.ready = s1_en;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        s1_valid_next  = s1_en ? req.valid : s1_valid_reg;
        s2_valid_next  = s2_en ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_en ? s2_valid_reg : out_valid_reg;
    end

    // config write; unknown index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_delay_cap <= MAD_RESET;
            cfg_reg.initial_rtt   <= INIT_RESET;
            cfg_reg.granularity   <= GRAN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ACK_DELAY_CAP: cfg_reg.ack_delay_cap <= cfg.data[MAD_W-1:0];
                CFG_INITIAL_RTT:   cfg_reg.initial_rtt   <= cfg.data[INIT_W-1:0];
                CFG_GRANULARITY:   cfg_reg.granularity   <= cfg.data[GRAN_W-1:0];
                default:           ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // estimator state moves with the item leaving stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_seen_reg   <= 1'b0;
            latest_rtt_reg    <= '0;
            minimum_rtt_reg   <= '0;
            smoothed_rtt_reg  <= '0;
            rtt_deviation_reg <= '0;
        end
        else if (s1_fire)
        begin
            sample_seen_reg   <= seen_new;
            latest_rtt_reg    <= latest_new;
            minimum_rtt_reg   <= minimum_new;
            smoothed_rtt_reg  <= smoothed_new;
            rtt_deviation_reg <= deviation_new;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_en && req.valid)
        begin
            s1_command_reg <= req.command;
            s1_time_reg    <= req.time_ms;
            s1_sent_reg    <= req.sent_time_ms;
            s1_ack_reg     <= req.ack_delay_ms;
            s1_count_reg   <= req.backoff_count;
        end
        if (s1_fire)
        begin
            s2_seen_reg      <= seen_new;
            s2_latest_reg    <= latest_new;
            s2_minimum_reg   <= minimum_new;
            s2_smoothed_reg  <= smoothed_new;
            s2_deviation_reg <= deviation_new;
            s2_time_reg      <= s1_time_reg;
            s2_count_reg     <= s1_count_reg;
        end
        if (s2_fire)
        begin
            out_latest_reg    <= OUT_RTT_W'(s2_latest_reg);
            out_minimum_reg   <= OUT_RTT_W'(s2_minimum_reg);
            out_smoothed_reg  <= OUT_RTT_W'(s2_smoothed_reg);
            out_deviation_reg <= OUT_RTT_W'(s2_deviation_reg);
            out_seen_reg      <= s2_seen_reg;
            out_loss_reg      <= loss_delay;
            out_pto_reg       <= pto_deadline;
        end
    end

    // sample clamp, min tracking and the smoothed / variance averages
    rtte_update #(
        .RTT_BITS (RTT_BITS)
    ) u_update (
        .ack_delay_cap (cfg_reg.ack_delay_cap),
        .command       (s1_command_reg),
        .time_ms       (s1_time_reg),
        .sent_time_ms  (s1_sent_reg),
        .ack_delay_ms  (s1_ack_reg),
        .seen          (sample_seen_reg),
        .latest        (latest_rtt_reg),
        .minimum       (minimum_rtt_reg),
        .smoothed      (smoothed_rtt_reg),
        .deviation     (rtt_deviation_reg),
        .seen_new      (seen_new),
        .latest_new    (latest_new),
        .minimum_new   (minimum_new),
        .smoothed_new  (smoothed_new),
        .deviation_new (deviation_new)
    );

    // loss delay and backed-off pto deadline from the updated state
    rtte_timers #(
        .RTT_BITS    (RTT_BITS),
        .MAX_BACKOFF (MAX_BACKOFF)
    ) u_timers (
        .ack_delay_cap   (cfg_reg.ack_delay_cap),
        .initial_rtt     (cfg_reg.initial_rtt),
        .granularity     (cfg_reg.granularity),
        .seen            (s2_seen_reg),
        .latest          (s2_latest_reg),
        .smoothed        (s2_smoothed_reg),
        .deviation       (s2_deviation_reg),
        .time_ms         (s2_time_reg),
        .backoff_count   (s2_count_reg),
        .loss_delay_ms   (loss_delay),
        .pto_deadline_ms (pto_deadline)
    );

    assign rsp.valid           = out_valid_reg;
    assign rsp.latest_rtt_ms   = out_latest_reg;
    assign rsp.min_rtt_ms      = out_minimum_reg;
    assign rsp.smoothed_rtt_ms = out_smoothed_reg;
    assign rsp.rtt_variance_ms = out_deviation_reg;
    assign rsp.have_sample     = out_seen_reg;
    assign rsp.loss_delay_ms   = out_loss_reg;
    assign rsp.pto_deadline_ms = out_pto_reg;

endmodule

// ----- tb/rtte_checker.sv -----
`timescale 1ns / 1ps

module rtte_checker (
    input  logic clk,
    input  logic rst_n,
    rtte_req_if  req,
    rtte_rsp_if  rsp,
    rtte_cfg_if  cfg,
    output int   errors,
    output int   outstanding,
    output int   checked
);
    import rtte_pkg::*;

    localparam logic [63:0] RTT_CEIL = (64'd1 << RTT_BITS_DEF) - 64'd1;

    typedef struct {
        logic [OUT_RTT_W-1:0]  latest;
        logic [OUT_RTT_W-1:0]  minimum;
        logic [OUT_RTT_W-1:0]  smoothed;
        logic [OUT_RTT_W-1:0]  variance;
        logic                  have;
        logic [LOSS_W-1:0]     loss;
        logic [DEADLINE_W-1:0] pto;
    } estimate_t;

    estimate_t estimate_q[$];

    // local copy of the registers and the estimator state
    cfg_t        settings;
    logic        seen;
    logic [63:0] last_rtt;
    logic [63:0] floor_rtt;
    logic [63:0] avg_rtt;
    logic [63:0] dev_rtt;

    task automatic fold_sample(input logic [63:0] now, input logic [63:0] sent,
                               input logic [63:0] ack);
        logic [63:0] rtt;
        logic [63:0] bound;
        logic [63:0] adj;
        logic [63:0] gap;
        rtt = (now >= sent) ? now - sent : 64'd0;
        if (rtt > RTT_CEIL)
            rtt = RTT_CEIL;
        last_rtt = rtt;
        if (!seen)
        begin
            seen      = 1'b1;
            floor_rtt = rtt;
            avg_rtt   = rtt;
            dev_rtt   = rtt >> 1;
        end
        else
        begin
            if (rtt < floor_rtt)
                floor_rtt = rtt;
            bound = (ack < 64'(settings.ack_delay_cap)) ? ack : 64'(settings.ack_delay_cap);
            adj   = rtt;
            if (rtt >= floor_rtt + bound)
                adj = rtt - bound;
            gap     = (avg_rtt > adj) ? avg_rtt - adj : adj - avg_rtt;
            dev_rtt = (dev_rtt * 3 + gap) / 4;
            avg_rtt = (avg_rtt * 7 + adj) / 8;
        end
    endtask

    function automatic estimate_t report(input logic [63:0] now, input logic [63:0] count);
        estimate_t   e;
        logic [63:0] base;
        logic [63:0] delay;
        logic [63:0] timeout;
        logic [63:0] var4;
        logic [63:0] steps;
        e.latest   = last_rtt[OUT_RTT_W-1:0];
        e.minimum  = floor_rtt[OUT_RTT_W-1:0];
        e.smoothed = avg_rtt[OUT_RTT_W-1:0];
        e.variance = dev_rtt[OUT_RTT_W-1:0];
        e.have     = seen;
        // loss delay: 9/8 of the larger rtt (initial rtt before a sample), rounded up
        if (seen)
            base = (last_rtt > avg_rtt) ? last_rtt : avg_rtt;
        else
            base = 64'(settings.initial_rtt);
        delay = (base * 9 + 7) / 8;
        if (delay < 64'(settings.granularity))
            delay = 64'(settings.granularity);
        if (delay > 64'(LOSS_MAX))
            delay = 64'(LOSS_MAX);
        e.loss = delay[LOSS_W-1:0];
        // probe timeout, doubled per backoff step with saturation
        if (seen)
        begin
            var4 = dev_rtt * 4;
            if (var4 < 64'(settings.granularity))
                var4 = 64'(settings.granularity);
            timeout = avg_rtt + var4 + 64'(settings.ack_delay_cap);
        end
        else
            timeout = 64'(settings.initial_rtt) * 3;
        if (timeout > 64'(TIMEOUT_MAX))
            timeout = 64'(TIMEOUT_MAX);
        steps = (count > 64'(MAX_BACKOFF_DEF)) ? 64'(MAX_BACKOFF_DEF) : count;
        for (int i = 0; i < int'(steps); i++)
        begin
            timeout = timeout * 2;
            if (timeout > 64'(TIMEOUT_MAX))
                timeout = 64'(TIMEOUT_MAX);
        end
        e.pto = DEADLINE_W'(now + timeout);
        return e;
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        estimate_t want;
        if (!rst_n)
        begin
            settings.ack_delay_cap = MAD_RESET;
            settings.initial_rtt   = INIT_RESET;
            settings.granularity   = GRAN_RESET;
            seen      = 1'b0;
            last_rtt  = '0;
            floor_rtt = '0;
            avg_rtt   = '0;
            dev_rtt   = '0;
            estimate_q.delete();
            outstanding = 0;
        end
        else
        begin
            // results first, so a transfer in this cycle cannot cover a stray result
            if (rsp.valid && rsp.ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    $error("result transfer with no expectation pending");
                    errors++;
                end
                else
                begin
                    want = estimate_q.pop_front();
                    compare_field("latest_rtt_ms", 64'(want.latest),
                                  64'(rsp.latest_rtt_ms));
                    compare_field("min_rtt_ms", 64'(want.minimum), 64'(rsp.min_rtt_ms));
                    compare_field("smoothed_rtt_ms", 64'(want.smoothed),
                                  64'(rsp.smoothed_rtt_ms));
                    compare_field("rtt_variance_ms", 64'(want.variance),
                                  64'(rsp.rtt_variance_ms));
                    compare_field("have_sample", 64'(want.have), 64'(rsp.have_sample));
                    compare_field("loss_delay_ms", 64'(want.loss), 64'(rsp.loss_delay_ms));
                    compare_field("pto_deadline_ms", 64'(want.pto),
                                  64'(rsp.pto_deadline_ms));
                    checked++;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_ACK_DELAY_CAP: settings.ack_delay_cap = cfg.data[MAD_W-1:0];
                    CFG_INITIAL_RTT:   settings.initial_rtt   = cfg.data[INIT_W-1:0];
                    CFG_GRANULARITY:   settings.granularity   = cfg.data[GRAN_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                if (req.command == CMD_SAMPLE)
                    fold_sample(64'(req.time_ms), 64'(req.sent_time_ms), 64'(req.ack_delay_ms));
                estimate_q.insert(estimate_q.size(),
                                  report(64'(req.time_ms), 64'(req.backoff_count)));
            end
            outstanding = estimate_q.size();
        end
    end

    initial
    begin
        errors      = 0;
        outstanding = 0;
        checked     = 0;
    end

endmodule

// ----- tb/rtt_estimator_with_pto_tb.sv -----
`timescale 1ns / 1ps

module rtt_estimator_with_pto_tb;
    import rtte_pkg::*;

    // index with no register behind it, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_ITEMS  = 232;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rtte_req_if req ();
    rtte_rsp_if rsp ();
    rtte_cfg_if cfg ();

    int errors;
    int outstanding;
    int checked;

    // stimulus bookkeeping
    bit          calm       = 1'b0;   // no idling on either side while set
    int          hold_ask   = 0;      // receiver stall request, in cycles
    int          items_sent = 0;
    int          samples    = 0;
    int          reg_writes = 0;
    int          cycles     = 0;
    logic [31:0] clock_ms;            // running ack time for well-formed samples
    int unsigned path_rtt;            // path rtt around which samples jitter

    rtt_estimator_with_pto uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    rtte_checker estimate_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random back-pressure, plus long hold-offs on request
    initial
    begin : rsp_side
        int hold_left;
        hold_left = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_ask > 0)
            begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // one req transfer, with random idle cycles in front; called and returns at negedge
    task automatic offer(input cmd_t cmd, input logic [31:0] now, input logic [31:0] sent,
                         input logic [15:0] ack, input logic [3:0] count);
        while (!calm && $urandom_range(99) < 25)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.command       <= cmd;
        req.time_ms       <= now;
        req.sent_time_ms  <= sent;
        req.ack_delay_ms  <= ack;
        req.backoff_count <= count;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (cmd == CMD_SAMPLE)
            samples++;
    endtask

    // register write, only once every result is out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        req.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    // mostly plausible acks around path_rtt; some noise with arbitrary times.
    // zero samples only when allowed: one of them pins the minimum at zero for good
    task automatic random_item(input bit zero_ok);
        int unsigned pick;
        logic [31:0] rtt;
        logic [31:0] now;
        logic [31:0] sent;
        logic [15:0] ack;
        cmd_t        cmd;
        pick = $urandom_range(99);
        cmd  = ($urandom_range(4) == 0) ? CMD_REPORT : CMD_SAMPLE;
        ack  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        if (pick < 10)
        begin
            // arbitrary times, every bit free when zero samples are allowed
            now  = $urandom;
            sent = $urandom;
            if (!zero_ok)
            begin
                if (now == 0)
                    now = 1;
                sent = now - (1 + $urandom_range(0, now - 1));
            end
        end
        else if (zero_ok && pick < 16)
        begin
            // ack before send
            now  = clock_ms;
            sent = clock_ms + $urandom_range(0, 5000);
        end
        else
        begin
            clock_ms = clock_ms + $urandom_range(0, 3000);
            rtt      = path_rtt + $urandom_range(0, path_rtt / 2 + 1);
            now      = clock_ms;
            sent     = clock_ms - rtt;
        end
        offer(cmd, now, sent, ack, 4'($urandom_range(0, 15)));
    endtask

    initial
    begin
        req.valid         = 1'b0;
        req.command       = CMD_SAMPLE;
        req.time_ms       = '0;
        req.sent_time_ms  = '0;
        req.ack_delay_ms  = '0;
        req.backoff_count = '0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_ACK_DELAY_CAP;
        cfg.data          = '0;
        clock_ms          = $urandom;
        path_rtt          = 100;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no sample yet: reports rest on the reset registers
        offer(CMD_REPORT, 32'd0, 32'd0, 16'd0, 4'd0);
        // largest time with full backoff, deadline carries into bit 32
        offer(CMD_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);

        // register extremes; data bits above each register's width are dropped
        write_reg(CFG_INITIAL_RTT, 16'hFFFF);
        write_reg(CFG_GRANULARITY, 16'hFFFF);
        write_reg(CFG_ACK_DELAY_CAP, 16'hFFFF);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        offer(CMD_REPORT, 32'd1234, 32'd0, 16'd0, 4'd15);   // timeout saturates
        offer(CMD_REPORT, 32'd0, 32'd0, 16'd0, 4'd1);
        write_reg(CFG_INITIAL_RTT, 16'd1);
        write_reg(CFG_GRANULARITY, 16'd0);
        offer(CMD_REPORT, 32'd10, 32'd5, 16'd7, 4'd0);

        write_reg(CFG_ACK_DELAY_CAP, 16'd20);
        write_reg(CFG_GRANULARITY, 16'd1);
        // first sample seeds smoothed and variance
        offer(CMD_SAMPLE, 32'd1000, 32'd900, 16'd5, 4'd0);
        // ack delay taken off
        offer(CMD_SAMPLE, 32'd2000, 32'd1880, 16'd10, 4'd2);
        // new minimum
        offer(CMD_SAMPLE, 32'd3000, 32'd2905, 16'd0, 4'd3);
        // ack delay bounded, but the adjustment would drop below the minimum
        offer(CMD_SAMPLE, 32'd4000, 32'd3890, 16'hFFFF, 4'd4);
        // bounded ack delay taken off
        offer(CMD_SAMPLE, 32'd5000, 32'd4700, 16'hFFFF, 4'd5);
        offer(CMD_REPORT, 32'hFFFF_FFFF, 32'd0, 16'd0, 4'd15);
        // huge sample saturates at the rtt width
        offer(CMD_SAMPLE, 32'hFFFF_FFFF, 32'd0, 16'h5555, 4'd7);
        offer(CMD_REPORT, 32'h5555_AAAA, 32'hAAAA_5555, 16'hAAAA, 4'd0);
        offer(CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FF00, 16'd300, 4'd8);
        offer(CMD_SAMPLE, 32'hAAAA_5555, 32'hAAAA_548D, 16'd40, 4'd10);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_ACK_DELAY_CAP, 16'($urandom_range(0, 200)));
                    write_reg(CFG_INITIAL_RTT, 16'($urandom_range(1, 65535)));
                    write_reg(CFG_GRANULARITY, 16'($urandom_range(0, 10)));
                    path_rtt = $urandom_range(50, 2000);
                end
                1:
                begin
                    // tight path with coarse timer: granularity floors show up
                    write_reg(CFG_ACK_DELAY_CAP, 16'd0);
                    write_reg(CFG_INITIAL_RTT, 16'($urandom_range(1, 65535)));
                    write_reg(CFG_GRANULARITY, 16'd255);
                    path_rtt = $urandom_range(1, 20);
                    calm     = 1'b1;
                end
                2:
                begin
                    write_reg(CFG_ACK_DELAY_CAP, 16'hFFFF);
                    write_reg(CFG_GRANULARITY, 16'd0);
                    write_reg(CFG_UNMAPPED, 16'($urandom));
                    path_rtt = $urandom_range(500, 100000);
                    calm     = 1'b0;
                end
                default:
                begin
                    write_reg(CFG_ACK_DELAY_CAP, 16'($urandom_range(0, 16383)));
                    write_reg(CFG_INITIAL_RTT, 16'd1);
                    write_reg(CFG_GRANULARITY, 16'($urandom_range(0, 255)));
                    path_rtt = $urandom_range(10, 5000);
                    // ack before send, the plain case and the widest one
                    offer(CMD_SAMPLE, 32'd100, 32'd200, 16'd0, 4'd0);
                    offer(CMD_SAMPLE, 32'd0, 32'hFFFF_FFFF, 16'd3, 4'd2);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long result stall while the sender keeps offering: pipe fills up
                if (ph == 2 && n == 40)
                    hold_ask = HOLD_CYCLES;
                random_item(ph == 3);
            end
        end
        req.valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d items (%0d rtt samples) across %0d register writes",
                 items_sent, samples, reg_writes);
        $display("%0d results compared with the predicted estimate, %0d mismatches",
                 checked, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
